### src/linear_head_dot_product_assert.svh
// Assertion macros shared by the linear head RTL.
`ifndef LINEAR_HEAD_DOT_PRODUCT_ASSERT_SVH
`define LINEAR_HEAD_DOT_PRODUCT_ASSERT_SVH

// Clocked check, muted while reset is asserted.
`define LHDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LHDP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/lhdp_pkg.sv
// Types and constants of the linear head dot-product engine.
`timescale 1ns / 1ps

package lhdp_pkg;

  localparam int unsigned IndexW  = 10;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned HeadW   = 5;
  localparam int unsigned RowW    = 12;
  localparam int unsigned CountW  = 11;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned AccW    = 48;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned LogitW  = 32;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CfgIdxW  = 1;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned OutUserW = 2;

  localparam logic [CountW-1:0] CountMax        = 11'd2047;
  localparam logic [CountW-1:0] HiddenInUseRst  = 11'd1024;
  localparam logic [ShiftW-1:0] ResultShiftRst  = 5'd11;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegHiddenInUse = 1'b0;
  localparam logic [CfgIdxW-1:0] RegResultShift = 1'b1;

  // Input item kinds carried on tuser.
  localparam logic ModeHidden = 1'b0;
  localparam logic ModeWeight = 1'b1;

  typedef struct packed {
    logic              length_error;
    logic              saturated;
    logic [RowW-1:0]   row_tag;
    logic [HeadW-1:0]  head_tag;
    logic [LogitW-1:0] logit;
  } result_t;

endpackage

### src/linear_head_dot_product.sv
// Linear head dot-product engine: hidden vector store, MAC pipeline, logit output.
`timescale 1ns / 1ps

// Streams one item per clock unless stalled. A hidden write (tuser = 0) lands
// in the on-chip vector store at element_index; a weight element (tuser = 1)
// is multiplied by the stored hidden element at the running row index and
// summed into a 48-bit Q21.27 accumulator. The weight marked tlast closes the
// row and yields one Q16.16 logit (floor shift by result_shift, then
// saturation) with its head and row tags, a saturation flag and a
// length-error flag. Throughput is one item per cycle while not stalled; the
// closing weight passes the synchronous read of the single-port hidden store
// at the accepting edge, then the 16x16 multiply register, the 48-bit
// accumulate register, and shift and saturate into the output register. The
// input stalls only while a finished result waits and the output register is
// still full. Hidden entries must be written before a row reads them.
module linear_head_dot_product #(
  parameter int unsigned HIDDEN_MAX = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [lhdp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [lhdp_pkg::CfgDataW-1:0]      cfg_data_i,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: element_index[9:0], value[25:10], head[30:26], row[42:31], zero pad
  input  logic [lhdp_pkg::InDataW-1:0]       s_axis_tdata_i,
  input  logic                               s_axis_tlast_i, // last_of_row
  input  logic                               s_axis_tuser_i, // mode
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: logit[31:0], head_tag[36:32], row_tag[48:37], zero pad
  output logic [lhdp_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // tuser: saturated[0], length_error[1]
  output logic [lhdp_pkg::OutUserW-1:0]      m_axis_tuser_o
);

  localparam int unsigned AW = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
  localparam int unsigned SWRaw = $clog2(HIDDEN_MAX + 1);
  localparam int unsigned SW = (SWRaw > lhdp_pkg::CountW) ? SWRaw : lhdp_pkg::CountW;
  localparam logic [SW-1:0] HiddenMaxS = SW'(HIDDEN_MAX);

  // ---------------------------------------------------------------- config
  logic [lhdp_pkg::CountW-1:0] hidden_in_use_q;
  logic [lhdp_pkg::ShiftW-1:0] result_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidden_in_use_q <= lhdp_pkg::HiddenInUseRst;
      result_shift_q  <= lhdp_pkg::ResultShiftRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lhdp_pkg::RegHiddenInUse: hidden_in_use_q <= cfg_data_i;
        lhdp_pkg::RegResultShift: result_shift_q  <= cfg_data_i[lhdp_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // size in use = min(hidden_in_use, HIDDEN_MAX)
  logic [SW-1:0] hiu_ext, size;
  assign hiu_ext = SW'(hidden_in_use_q);
  assign size    = (hiu_ext < HiddenMaxS) ? hiu_ext : HiddenMaxS;

  // ---------------------------------------------------------------- input unpack
  logic [lhdp_pkg::IndexW-1:0] in_pos;
  logic [lhdp_pkg::ValueW-1:0] in_val;
  logic [lhdp_pkg::HeadW-1:0]  in_head;
  logic [lhdp_pkg::RowW-1:0]   in_row;

  assign in_pos  = s_axis_tdata_i[9:0];
  assign in_val  = s_axis_tdata_i[25:10];
  assign in_head = s_axis_tdata_i[30:26];
  assign in_row  = s_axis_tdata_i[42:31];

  // ---------------------------------------------------------------- flow control
  logic stall, adv, accept;
  logic r3_vld_q, out_vld_q;

  // freeze the pipe only when a finished result cannot move into the output reg
  assign stall  = r3_vld_q && out_vld_q && !m_axis_tready_i;
  assign adv    = !stall;
  assign s_axis_tready_o = adv;
  assign accept = s_axis_tvalid_i && adv;

  logic acc_wt, acc_hid;
  assign acc_wt  = accept && (s_axis_tuser_i == lhdp_pkg::ModeWeight);
  assign acc_hid = accept && (s_axis_tuser_i == lhdp_pkg::ModeHidden);

  // ---------------------------------------------------------------- element count
  logic [lhdp_pkg::CountW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [SW-1:0]               cnt_ext;
  logic                        cnt_in_range, cnt_len_err;

  assign cnt_ext      = SW'(cnt_q);
  assign cnt_in_range = cnt_ext < size;
  assign cnt_inc      = (cnt_q != lhdp_pkg::CountMax) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_len_err  = SW'(cnt_inc) != size;

  always_comb begin
    cnt_d = cnt_q;
    if (acc_wt) begin
      cnt_d = s_axis_tlast_i ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // ---------------------------------------------------------------- hidden store
  logic [lhdp_pkg::ValueW-1:0] hidden_mem [HIDDEN_MAX];
  logic [lhdp_pkg::ValueW-1:0] rdata_q;
  logic [SW-1:0]               pos_ext;
  logic                        wr_en;
  logic [AW-1:0]               waddr, raddr;

  assign pos_ext = SW'(in_pos);
  assign wr_en   = acc_hid && (pos_ext < HiddenMaxS);
  assign waddr   = pos_ext[AW-1:0];
  assign raddr   = cnt_ext[AW-1:0];

  // a hidden write is done at its own edge, so a later weight reads it fresh
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hidden_mem[waddr] <= in_val;
    end
    if (acc_wt) begin
      rdata_q <= hidden_mem[raddr];
    end
  end

  // ---------------------------------------------------------------- stage 1: read
  logic                        s1_vld_q, s1_inr_q, s1_last_q, s1_lerr_q;
  logic [lhdp_pkg::ValueW-1:0] s1_w_q;
  logic [lhdp_pkg::HeadW-1:0]  s1_head_q;
  logic [lhdp_pkg::RowW-1:0]   s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= acc_wt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_wt) begin
      s1_inr_q  <= cnt_in_range;
      s1_last_q <= s_axis_tlast_i;
      s1_lerr_q <= cnt_len_err;
      s1_w_q    <= in_val;
      s1_head_q <= in_head;
      s1_row_q  <= in_row;
    end
  end

  // ---------------------------------------------------------------- stage 2: multiply
  logic                        s2_vld_q, s2_inr_q, s2_last_q, s2_lerr_q;
  logic [lhdp_pkg::ProdW-1:0]  s2_prod_q;
  logic [lhdp_pkg::HeadW-1:0]  s2_head_q;
  logic [lhdp_pkg::RowW-1:0]   s2_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q) begin
      s2_inr_q  <= s1_inr_q;
      s2_last_q <= s1_last_q;
      s2_lerr_q <= s1_lerr_q;
      s2_prod_q <= lhdp_pkg::ProdW'($signed(rdata_q) * $signed(s1_w_q));
      s2_head_q <= s1_head_q;
      s2_row_q  <= s1_row_q;
    end
  end

  // ---------------------------------------------------------------- stage 3: accumulate
  logic [lhdp_pkg::AccW-1:0]   acc_q, acc_d, acc_sum, prod_ext;
  logic [lhdp_pkg::AccW-1:0]   fin_q;
  logic [lhdp_pkg::HeadW-1:0]  r3_head_q;
  logic [lhdp_pkg::RowW-1:0]   r3_row_q;
  logic                        r3_lerr_q;
  logic                        s2_ends_row;

  // elements past the size in use count but add nothing
  assign prod_ext    = s2_inr_q ? lhdp_pkg::AccW'($signed(s2_prod_q)) : '0;
  assign acc_sum     = acc_q + prod_ext;
  assign s2_ends_row = s2_vld_q && s2_last_q;

  always_comb begin
    acc_d = acc_q;
    if (adv && s2_vld_q) begin
      acc_d = s2_last_q ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      r3_vld_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (adv) begin
        r3_vld_q <= s2_ends_row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_ends_row) begin
      fin_q     <= acc_sum;
      r3_head_q <= s2_head_q;
      r3_row_q  <= s2_row_q;
      r3_lerr_q <= s2_lerr_q;
    end
  end

  // ---------------------------------------------------------------- shift, saturate, output
  logic [lhdp_pkg::AccW-1:0] shifted;
  logic                      fin_neg, clip;
  lhdp_pkg::result_t         res_d, res_q;

  assign shifted = lhdp_pkg::AccW'($signed(fin_q) >>> result_shift_q);
  assign fin_neg = fin_q[lhdp_pkg::AccW-1];
  // fits in 32 bits only when bits 47..31 all match the sign
  assign clip    = fin_neg ? !(&shifted[lhdp_pkg::AccW-1:lhdp_pkg::LogitW-1])
                           :  (|shifted[lhdp_pkg::AccW-1:lhdp_pkg::LogitW-1]);

  always_comb begin
    res_d.length_error = r3_lerr_q;
    res_d.saturated    = clip;
    res_d.row_tag      = r3_row_q;
    res_d.head_tag     = r3_head_q;
    if (!clip) begin
      res_d.logit = shifted[lhdp_pkg::LogitW-1:0];
    end else if (fin_neg) begin
      res_d.logit = {1'b1, {(lhdp_pkg::LogitW-1){1'b0}}};
    end else begin
      res_d.logit = {1'b0, {(lhdp_pkg::LogitW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && r3_vld_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && r3_vld_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, res_q.row_tag, res_q.head_tag, res_q.logit};
  assign m_axis_tuser_o  = {res_q.length_error, res_q.saturated};

  // ---------------------------------------------------------------- assertions
`include "linear_head_dot_product_assert.svh"

  `LHDP_ASSERT(a_result_held, stall |=> r3_vld_q, "finished result dropped while stalled")
  `LHDP_ASSERT(a_result_lands, (r3_vld_q && adv) |=> out_vld_q, "result missed the output reg")
  `LHDP_ASSERT(a_row_clears, acc_wt && s_axis_tlast_i |=> cnt_q == '0, "count kept after row end")
  `LHDP_ASSERT_ALWAYS(a_no_accept_stall, !(s_axis_tready_o && stall), "input taken while frozen")

endmodule

### dv/testbench.sv
// Self-checking testbench for the linear head dot-product engine.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned HiddenMax   = 1024;
  localparam int unsigned FillDepth   = 32;   // covers every index the rows below read
  localparam int unsigned DrainCycles = 8;    // four-stage pipe plus margin
  localparam int unsigned QuietLimit  = 5000; // cycles with no request moving on either side
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned InPadW      = lhdp_pkg::InDataW - lhdp_pkg::IndexW
                                        - lhdp_pkg::ValueW - lhdp_pkg::HeadW
                                        - lhdp_pkg::RowW;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [lhdp_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [lhdp_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [lhdp_pkg::InDataW-1:0]  s_axis_tdata_i;
  logic                          s_axis_tlast_i;
  logic                          s_axis_tuser_i;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [lhdp_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic [lhdp_pkg::OutUserW-1:0] m_axis_tuser_o;

  linear_head_dot_product #(
    .HIDDEN_MAX(HiddenMax)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Shadow of the engine state, advanced on every accepted input request.
  logic signed [lhdp_pkg::ValueW-1:0] hidden_copy [HiddenMax];
  logic [lhdp_pkg::AccW-1:0]          acc_copy           = '0;
  logic [lhdp_pkg::CountW-1:0]        count_copy         = '0;
  logic [lhdp_pkg::CountW-1:0]        hidden_in_use_copy = lhdp_pkg::HiddenInUseRst;
  logic [lhdp_pkg::ShiftW-1:0]        shift_copy         = lhdp_pkg::ResultShiftRst;
  lhdp_pkg::result_t                  pending_logits[$];

  int mismatches  = 0;
  int items_sent  = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left   = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // One step: a hidden write, or one MAC step that closes the row on the last weight.
  function automatic void dot_product_step(logic mode, logic [lhdp_pkg::IndexW-1:0] idx,
                                           logic signed [lhdp_pkg::ValueW-1:0] value,
                                           logic last, logic [lhdp_pkg::HeadW-1:0] head,
                                           logic [lhdp_pkg::RowW-1:0] row);
    int unsigned       size;
    int                prod;
    longint            wide;
    lhdp_pkg::result_t res;
    size = (hidden_in_use_copy < HiddenMax) ? hidden_in_use_copy : HiddenMax;
    if (mode == lhdp_pkg::ModeHidden) begin
      hidden_copy[idx] = value; // tlast means nothing here
      return;
    end
    // weights past the size are counted but not summed
    if (count_copy < size) begin
      prod     = int'(hidden_copy[count_copy[lhdp_pkg::IndexW-1:0]]) * int'(value);
      acc_copy = acc_copy + {{(lhdp_pkg::AccW-lhdp_pkg::ProdW){prod[31]}}, prod};
    end
    if (count_copy != lhdp_pkg::CountMax) count_copy++;
    if (!last) return;
    // arithmetic shift floors toward minus infinity, then clip to 32 bits
    wide = longint'($signed(acc_copy)) >>> shift_copy;
    res.saturated = 1'b1;
    if (wide > 64'sd2147483647) begin
      res.logit = 32'h7FFF_FFFF;
    end else if (wide < -64'sd2147483648) begin
      res.logit = 32'h8000_0000;
    end else begin
      res.logit     = wide[lhdp_pkg::LogitW-1:0];
      res.saturated = 1'b0;
    end
    res.head_tag     = head;
    res.row_tag      = row;
    res.length_error = (count_copy != size);
    pending_logits.push_back(res);
    acc_copy   = '0;
    count_copy = '0;
  endfunction

  function automatic logic signed [lhdp_pkg::ValueW-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return lhdp_pkg::ValueW'($urandom);
    endcase
  endfunction

  // Offer one request; valid stays high on return so back-to-back requests stream.
  task automatic send_item(logic mode, logic [lhdp_pkg::IndexW-1:0] idx,
                           logic signed [lhdp_pkg::ValueW-1:0] value, logic last,
                           logic [lhdp_pkg::HeadW-1:0] head, logic [lhdp_pkg::RowW-1:0] row);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tlast_i  <= last;
    s_axis_tdata_i  <= {{InPadW{1'b0}}, row, head, value, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    dot_product_step(mode, idx, value, last, head, row);
  endtask

  task automatic write_hidden();
    send_item(lhdp_pkg::ModeHidden, lhdp_pkg::IndexW'($urandom), pick_value(), 1'($urandom),
              lhdp_pkg::HeadW'($urandom), lhdp_pkg::RowW'($urandom));
  endtask

  task automatic send_row(int len, bit mix_writes);
    logic [lhdp_pkg::HeadW-1:0] head;
    logic [lhdp_pkg::RowW-1:0]  row;
    head = lhdp_pkg::HeadW'($urandom);
    row  = lhdp_pkg::RowW'($urandom);
    for (int i = 0; i < len; i++) begin
      if (mix_writes && $urandom_range(9) == 0) write_hidden();
      send_item(lhdp_pkg::ModeWeight, lhdp_pkg::IndexW'($urandom), pick_value(), i == len - 1,
                head, row);
    end
  endtask

  // Idle the input, let every logit come back, then let the pipe empty.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_logits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [lhdp_pkg::CfgIdxW-1:0] idx,
                         logic [lhdp_pkg::CfgDataW-1:0] data);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lhdp_pkg::RegHiddenInUse) hidden_in_use_copy = data;
    else shift_copy = data[lhdp_pkg::ShiftW-1:0];
  endtask

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // hidden extremes; tlast on a hidden write is ignored
    send_item(lhdp_pkg::ModeHidden, 0, 16'sh7FFF, 1, 0, 0);
    send_item(lhdp_pkg::ModeHidden, 1, 16'sh8000, 0, 31, 4095);
    send_item(lhdp_pkg::ModeHidden, 2, 16'sh1000, 1, 0, 0);
    send_item(lhdp_pkg::ModeHidden, 3, -16'sd1, 0, 0, 0);
    // short row at reset size -> length error
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh8000, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 1023, 16'sh7FFF, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh0001, 1, 0, 0);
    // positive clip at shift 0, top head tag, top row tag
    set_reg(lhdp_pkg::RegHiddenInUse, 4);
    set_reg(lhdp_pkg::RegResultShift, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh7FFF, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh8000, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh7FFF, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh0000, 1, 31, 4095);
    // negative clip
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh8000, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh7FFF, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh8000, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh0000, 1, 16, 1);
    // hidden write in the middle of a row; weight past the size adds nothing
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh0001, 0, 0, 0);
    send_item(lhdp_pkg::ModeHidden, 1, 16'sh0123, 1, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh0001, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh0001, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh0001, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh7FFF, 1, 1, 2);
    // floor on a tiny negative sum gives -1
    set_reg(lhdp_pkg::RegResultShift, 31);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh0000, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh0000, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh0000, 0, 0, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh0001, 1, 2, 3);
    // size zero flags every row
    set_reg(lhdp_pkg::RegHiddenInUse, 0);
    send_item(lhdp_pkg::ModeWeight, 0, 16'sh7FFF, 1, 5, 77);
  endtask

  // Fills the low store entries, so every later read hits a written entry.
  task automatic test_fill_store();
    tx_idle_pct = 10;
    rx_idle_pct = 50;
    set_reg(lhdp_pkg::RegHiddenInUse, lhdp_pkg::CfgDataW'(FillDepth));
    set_reg(lhdp_pkg::RegResultShift, lhdp_pkg::CfgDataW'(lhdp_pkg::ResultShiftRst));
    for (int i = 0; i < FillDepth; i++) begin
      send_item(lhdp_pkg::ModeHidden, lhdp_pkg::IndexW'(i), pick_value(), 1'($urandom),
                lhdp_pkg::HeadW'($urandom), lhdp_pkg::RowW'($urandom));
    end
    send_row(FillDepth, 1'b0);
  endtask

  // Receiver holds off long enough for the pipe to fill and stall the input.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_reg(lhdp_pkg::RegHiddenInUse, 1);
    hold_left = HoldCycles;
    repeat (60) send_row(1, 1'b0);
  endtask

  task automatic test_random(int items, int tx_pct, int rx_pct);
    int start;
    int hsize;
    int eff;
    int len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = items_sent;
    while (items_sent - start < items) begin
      case ($urandom_range(9))
        0:       hsize = 0;
        1:       hsize = HiddenMax;
        2:       hsize = 2047;
        3:       hsize = $urandom_range(2047);
        default: hsize = $urandom_range(1, 16);
      endcase
      set_reg(lhdp_pkg::RegHiddenInUse, lhdp_pkg::CfgDataW'(hsize));
      case ($urandom_range(3))
        0:       set_reg(lhdp_pkg::RegResultShift, 0);
        1:       set_reg(lhdp_pkg::RegResultShift, 31);
        default: set_reg(lhdp_pkg::RegResultShift, lhdp_pkg::CfgDataW'($urandom_range(31)));
      endcase
      eff = (hsize < HiddenMax) ? hsize : HiddenMax;
      repeat ($urandom_range(5, 15)) begin
        case ($urandom_range(9))
          0:       len = 1;
          1:       len = $urandom_range(1, 24);
          2:       len = (eff >= 1 && eff <= 24) ? eff + 1 : 1;
          3: begin
            // noise: stray hidden writes between rows
            repeat ($urandom_range(1, 4)) write_hidden();
            len = 0;
          end
          default: len = (eff >= 1 && eff <= 24) ? eff : $urandom_range(1, 24);
        endcase
        send_row(len, 1'b1);
      end
    end
  endtask

  // Receiver side: random or held-off ready.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Each delivered logit against the oldest finished row.
  always @(posedge clk_i) begin : logit_check
    lhdp_pkg::result_t got;
    lhdp_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.logit        = m_axis_tdata_o[lhdp_pkg::LogitW-1:0];
      got.head_tag     = m_axis_tdata_o[lhdp_pkg::LogitW +: lhdp_pkg::HeadW];
      got.row_tag      = m_axis_tdata_o[lhdp_pkg::LogitW+lhdp_pkg::HeadW +: lhdp_pkg::RowW];
      got.saturated    = m_axis_tuser_o[0];
      got.length_error = m_axis_tuser_o[1];
      if (pending_logits.size() == 0) begin
        report_mismatch($sformatf("logit %h for row %0d with no row pending",
                                  got.logit, got.row_tag));
      end else begin
        want = pending_logits.pop_front();
        if (got.logit !== want.logit)
          report_mismatch($sformatf("logit: expected %h got %h", want.logit, got.logit));
        if (got.head_tag !== want.head_tag)
          report_mismatch($sformatf("head_tag: expected %0d got %0d",
                                    want.head_tag, got.head_tag));
        if (got.row_tag !== want.row_tag)
          report_mismatch($sformatf("row_tag: expected %0d got %0d", want.row_tag, got.row_tag));
        if (got.saturated !== want.saturated)
          report_mismatch($sformatf("saturated: expected %b got %b",
                                    want.saturated, got.saturated));
        if (got.length_error !== want.length_error)
          report_mismatch($sformatf("length_error: expected %b got %b",
                                    want.length_error, got.length_error));
      end
    end
  end

  // Ends the run when no request moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) quiet = 0;
      else quiet++;
    end
    $display("linear_head_dot_product test failed");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= lhdp_pkg::RegHiddenInUse;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    s_axis_tuser_i  <= lhdp_pkg::ModeHidden;
    m_axis_tready_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_store();
    test_backpressure();
    test_random(500, 34, 85);
    test_random(500, 85, 34);
    test_random(500, 0, 0);
    wait_drained();

    if (mismatches == 0) begin
      $display("linear_head_dot_product test passed");
    end else begin
      $display("linear_head_dot_product test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/lhdp_pkg.sv
src/linear_head_dot_product.sv
dv/testbench.sv
